// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the RTL files.
// All checks sample on the rising edge of clk and are disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ===== hdl/ttn_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttn_pkg: shared definitions of the two-tone NCO
// Widths, register reset values, register index codes and the quarter-wave
// cosine table generator used at elaboration.
// ----------------------------------------------------------------------------
package ttn_pkg;

	// Parameter defaults
	localparam int PHASE_WIDTH_DEF   = 32;
	localparam int COS_ADDR_BITS_DEF = 12;
	localparam int AMP_WIDTH_DEF     = 16;
	localparam int QUEUE_DEPTH       = 4;

	// Fixed field widths
	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_AMP_W  = 16;
	localparam int STEP_W     = 32;
	localparam int NOISE_W    = 32;
	localparam int SAMPLE_W   = 19;
	localparam int ROM_W      = 15;

	// Output clamp limits (19-bit two's complement)
	localparam int OUT_MAX = 262143;
	localparam int OUT_MIN = -262144;

	// Register resets (X-axis defaults)
	localparam logic [STEP_W-1:0]    TONE1_STEP_RST = 32'd8388608;
	localparam logic [CFG_AMP_W-1:0] TONE1_AMP_RST  = 16'd5243;
	localparam logic [STEP_W-1:0]    TONE2_STEP_RST = 32'd0;
	localparam logic [CFG_AMP_W-1:0] TONE2_AMP_RST  = 16'd0;
	localparam logic [CFG_AMP_W-1:0] NOISE_GAIN_RST = 16'd1049;

	// Register index codes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TONE1_STEP = 3'd0,
		REG_TONE1_AMP  = 3'd1,
		REG_TONE2_STEP = 3'd2,
		REG_TONE2_AMP  = 3'd3,
		REG_NOISE_GAIN = 3'd4
	} cfg_reg_t;

	// Taylor coefficients of cos(pi/2*u) in powers of u^2, Q30
	localparam logic [63:0] CK1 = 64'd1324675879;
	localparam logic [63:0] CK2 = 64'd272375559;
	localparam logic [63:0] CK3 = 64'd22401993;
	localparam logic [63:0] CK4 = 64'd987047;
	localparam logic [63:0] CK5 = 64'd27061;

	// One quarter-wave entry, unsigned Q0.15; index 2^qbits and above reads as zero.
	// Only evaluated on constants while the table is built.
	function automatic logic [ROM_W-1:0] cos_rom_entry(input int unsigned idx,
		input int unsigned qbits);
		logic [63:0]        u;
		logic [63:0]        z;
		logic [63:0]        p;
		logic signed [63:0] c;
		logic signed [63:0] r;
		logic [ROM_W-1:0]   res;
		res = '0;
		if (64'(idx) < (64'd1 << qbits)) begin
			u = 64'(idx) << (30 - qbits);
			z = (u * u) >> 30;
			p = CK5;
			p = CK4 - ((z * p) >> 30);
			p = CK3 - ((z * p) >> 30);
			p = CK2 - ((z * p) >> 30);
			p = CK1 - ((z * p) >> 30);
			c = $signed(64'd1 << 30) - $signed((z * p) >> 30);
			if (c < 0) begin
				c = 0;
			end
			r = (c + 64'sd16384) >>> 15;
			if (r > 64'sd32767) begin
				r = 64'sd32767;
			end
			res = r[ROM_W-1:0];
		end
		return res;
	endfunction

endpackage

// ===== hdl/ttn_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttn_if: stream channels of the two-tone NCO
// Tick channel carries one noise word per sample; sample channel carries
// one generated acceleration word.
// ----------------------------------------------------------------------------
interface ttn_tick_if import ttn_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [NOISE_W-1:0] noise_word;

	modport source (output valid, output noise_word, input ready);
	modport sink   (input valid, input noise_word, output ready);
endinterface

interface ttn_sample_if import ttn_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

// ===== hdl/two_tone_nco_with_noise_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_tone_nco_with_noise_top: two-tone NCO vibration source with noise
// Per tick: amp1*cos(phase1) + amp2*cos(phase2) (tone two only with a
// nonzero step) + noise gain*noise_word/2^31, then both phases advance.
//
//   channel  role    word                      handshake
//   tick     sink    noise_word, s32           valid/ready
//   accel    source  sample, s19 (2^-20 g)     valid/ready
//   cfg      write   cfg_index, cfg_data[31:0] cfg_we, no wait
//
// One tick per clock while the queue has room; the phase add is the only loop
// and closes through the phase registers. A sample passes through the queue
// and the table read, multiply, round and sum registers after its tick is taken.
// Reset clears phases, queue and pipeline valids and loads the X-axis
// register defaults; the table is constant, so no clearing pass.
// tick.ready drops only when the four-word queue is full; a stalled sample
// holds in the output register while the pipeline and queue keep filling.
// ----------------------------------------------------------------------------
module two_tone_nco_with_noise_top import ttn_pkg::*; #(
	parameter int PHASE_WIDTH   = PHASE_WIDTH_DEF,
	parameter int COS_ADDR_BITS = COS_ADDR_BITS_DEF,
	parameter int AMP_WIDTH     = AMP_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	ttn_tick_if.sink              tick,
	ttn_sample_if.source          accel,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int AMP_EFF_W = (AMP_WIDTH < CFG_AMP_W) ? AMP_WIDTH : CFG_AMP_W;
	localparam int ENTRY_W   = 2 * (COS_ADDR_BITS - 1) + 3 + NOISE_W;

	logic                 push_valid, push_ready;
	logic [ENTRY_W-1:0]   push_data;
	logic                 pop_valid, pop_ready;
	logic [ENTRY_W-1:0]   pop_data;
	logic [AMP_EFF_W-1:0] amp1, amp2, namp;

	// Front: registers, phases, address decode
	ttn_front #(
		.PHASE_WIDTH  (PHASE_WIDTH),
		.COS_ADDR_BITS(COS_ADDR_BITS),
		.AMP_WIDTH    (AMP_WIDTH),
		.ENTRY_W      (ENTRY_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick      (tick),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data),
		.amp1      (amp1),
		.amp2      (amp2),
		.namp      (namp)
	);

	// Decoupling queue
	ttn_queue #(
		.WIDTH(ENTRY_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data)
	);

	// Back: lookup, scale, round, sum
	ttn_back #(
		.COS_ADDR_BITS(COS_ADDR_BITS),
		.AMP_WIDTH    (AMP_WIDTH),
		.ENTRY_W      (ENTRY_W)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_data (pop_data),
		.amp1     (amp1),
		.amp2     (amp2),
		.namp     (namp),
		.accel    (accel)
	);

endmodule

// ===== hdl/ttn_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttn_front: register file, phase accumulators and cosine address decode
// Takes one tick word per cycle while the queue has room, turns both phases
// into quarter-wave addresses and sign flags, and advances the phases.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ttn_front import ttn_pkg::*; #(
	parameter int PHASE_WIDTH   = PHASE_WIDTH_DEF,
	parameter int COS_ADDR_BITS = COS_ADDR_BITS_DEF,
	parameter int AMP_WIDTH     = AMP_WIDTH_DEF,
	parameter int ENTRY_W       = 2 * (COS_ADDR_BITS - 1) + 3 + NOISE_W
) (
	input  logic                  clk,
	input  logic                  arst_n,
	ttn_tick_if.sink              tick,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  push_valid,
	input  logic                  push_ready,
	output logic [ENTRY_W-1:0]    push_data,
	output logic [(AMP_WIDTH < CFG_AMP_W ? AMP_WIDTH : CFG_AMP_W)-1:0] amp1,
	output logic [(AMP_WIDTH < CFG_AMP_W ? AMP_WIDTH : CFG_AMP_W)-1:0] amp2,
	output logic [(AMP_WIDTH < CFG_AMP_W ? AMP_WIDTH : CFG_AMP_W)-1:0] namp
);

	localparam int AMP_EFF_W = (AMP_WIDTH < CFG_AMP_W) ? AMP_WIDTH : CFG_AMP_W;
	localparam int QBITS     = COS_ADDR_BITS - 2;
	localparam int ADDR_W    = QBITS + 1;
	localparam int QSIZE     = 1 << QBITS;

	logic [STEP_W-1:0]    step1_q, step2_q;
	logic [AMP_EFF_W-1:0] amp1_q, amp2_q, namp_q;
	logic [PHASE_WIDTH-1:0] phase1_q, phase2_q;

	logic [PHASE_WIDTH+STEP_W-1:0] step1_ext, step2_ext;
	logic [PHASE_WIDTH-1:0]        step1_pw, step2_pw;
	logic [COS_ADDR_BITS-1:0]      top1, top2;
	logic [ADDR_W-1:0]             addr1, addr2;
	logic                          neg1, neg2, en2;
	logic                          take;

	// Register writes; indexes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step1_q <= TONE1_STEP_RST;
			amp1_q  <= TONE1_AMP_RST[AMP_EFF_W-1:0];
			step2_q <= TONE2_STEP_RST;
			amp2_q  <= TONE2_AMP_RST[AMP_EFF_W-1:0];
			namp_q  <= NOISE_GAIN_RST[AMP_EFF_W-1:0];
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_TONE1_STEP: step1_q <= cfg_data[STEP_W-1:0];
				REG_TONE1_AMP:  amp1_q  <= cfg_data[AMP_EFF_W-1:0];
				REG_TONE2_STEP: step2_q <= cfg_data[STEP_W-1:0];
				REG_TONE2_AMP:  amp2_q  <= cfg_data[AMP_EFF_W-1:0];
				REG_NOISE_GAIN: namp_q  <= cfg_data[AMP_EFF_W-1:0];
				default: ;
			endcase
		end
	end

	assign amp1 = amp1_q;
	assign amp2 = amp2_q;
	assign namp = namp_q;

	// Step fitted to the phase width (truncate or zero-extend)
	assign step1_ext = {{PHASE_WIDTH{1'b0}}, step1_q};
	assign step2_ext = {{PHASE_WIDTH{1'b0}}, step2_q};
	assign step1_pw  = step1_ext[PHASE_WIDTH-1:0];
	assign step2_pw  = step2_ext[PHASE_WIDTH-1:0];

	// Quadrant decode: odd quadrants mirror the index, middle two negate
	assign top1  = phase1_q[PHASE_WIDTH-1 -: COS_ADDR_BITS];
	assign top2  = phase2_q[PHASE_WIDTH-1 -: COS_ADDR_BITS];
	assign addr1 = top1[QBITS] ? (ADDR_W'(QSIZE) - {1'b0, top1[QBITS-1:0]})
		: {1'b0, top1[QBITS-1:0]};
	assign addr2 = top2[QBITS] ? (ADDR_W'(QSIZE) - {1'b0, top2[QBITS-1:0]})
		: {1'b0, top2[QBITS-1:0]};
	assign neg1  = top1[QBITS+1] ^ top1[QBITS];
	assign neg2  = top2[QBITS+1] ^ top2[QBITS];
	assign en2   = |step2_q;

	// Handshake straight into the queue
	assign take       = tick.valid && push_ready;
	assign tick.ready = push_ready;
	assign push_valid = tick.valid;
	assign push_data  = {en2, neg2, addr2, neg1, addr1, tick.noise_word};

	// Phase accumulators advance once per accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase1_q <= '0;
			phase2_q <= '0;
		end else if (take) begin
			phase1_q <= phase1_q + step1_pw;
			phase2_q <= phase2_q + step2_pw;
		end
	end

	`ASSERT_CLK(a_phase_adv, take |=> phase1_q == PHASE_WIDTH'($past(phase1_q) + $past(step1_pw)), "tone 1 phase did not advance by its step")
	`ASSERT_CLK(a_phase_hold, !take |=> $stable(phase1_q) && $stable(phase2_q), "phase moved without a tick")

endmodule

// ===== hdl/ttn_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttn_queue: small FIFO between front and back
// Holds decoded tick words so either side can stall on its own.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ttn_queue import ttn_pkg::*; #(
	parameter int WIDTH = NOISE_W,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push, pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`ASSERT_NEVER(a_count_bound, count_q > CNT_W'(DEPTH), "queue fill count beyond depth")
	`ASSERT_CLK(a_count_inc, push && !pop |=> count_q == CNT_W'($past(count_q) + 1'b1), "queue count did not follow a push")

endmodule

// ===== hdl/ttn_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttn_back: cosine lookup, scaling, rounding and summing
// Four-stage pipeline: table read, multiply, round, sum and clamp into the
// output register. Each stage moves when the next one is empty or moving.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ttn_back import ttn_pkg::*; #(
	parameter int COS_ADDR_BITS = COS_ADDR_BITS_DEF,
	parameter int AMP_WIDTH     = AMP_WIDTH_DEF,
	parameter int ENTRY_W       = 2 * (COS_ADDR_BITS - 1) + 3 + NOISE_W
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pop_valid,
	output logic               pop_ready,
	input  logic [ENTRY_W-1:0] pop_data,
	input  logic [(AMP_WIDTH < CFG_AMP_W ? AMP_WIDTH : CFG_AMP_W)-1:0] amp1,
	input  logic [(AMP_WIDTH < CFG_AMP_W ? AMP_WIDTH : CFG_AMP_W)-1:0] amp2,
	input  logic [(AMP_WIDTH < CFG_AMP_W ? AMP_WIDTH : CFG_AMP_W)-1:0] namp,
	ttn_sample_if.source       accel
);

	localparam int AMP_EFF_W = (AMP_WIDTH < CFG_AMP_W) ? AMP_WIDTH : CFG_AMP_W;
	localparam int QBITS     = COS_ADDR_BITS - 2;
	localparam int ADDR_W    = QBITS + 1;
	localparam int ROM_DEPTH = (1 << QBITS) + 1;
	localparam int TP_W      = AMP_EFF_W + ROM_W + 2;
	localparam int NP_W      = AMP_EFF_W + 1 + NOISE_W;
	localparam int TERM_W    = AMP_EFF_W + 3;
	localparam int SUM_W     = TERM_W + 2;
	localparam int TONE_HALF  = 1 << 14;
	localparam int NOISE_HALF = 1 << 30;
	localparam int SAMPLE_BOUND = 3 * ((1 << AMP_EFF_W) - 1);

	// Entry field offsets, packed by the front
	localparam int A1_LO = NOISE_W;
	localparam int N1_BIT = A1_LO + ADDR_W;
	localparam int A2_LO = N1_BIT + 1;
	localparam int N2_BIT = A2_LO + ADDR_W;
	localparam int E2_BIT = N2_BIT + 1;

	typedef logic [ROM_W-1:0] rom_word_t;
	typedef rom_word_t rom_arr_t [ROM_DEPTH];

	function automatic rom_arr_t build_rom();
		rom_arr_t r;
		for (int j = 0; j < ROM_DEPTH; j++) begin
			r[j] = cos_rom_entry(j, QBITS);
		end
		return r;
	endfunction

	localparam rom_arr_t COS_ROM = build_rom();

	logic adv1, adv2, adv3, adv_o;
	logic v_s1, v_s2, v_s3, out_v_q;

	logic [ROM_W-1:0]          rom1_s1, rom2_s1;
	logic                      neg1_s1, neg2_s1, en2_s1, en2_s2;
	logic signed [NOISE_W-1:0] noise_s1;
	logic signed [TP_W-1:0]    p1_s2, p2_s2;
	logic signed [NP_W-1:0]    pn_s2;
	logic signed [TERM_W-1:0]  t1_s3, t2_s3, tn_s3;
	logic signed [SAMPLE_W-1:0] sample_q;

	logic signed [ROM_W:0]  cos1, cos2;
	logic signed [TP_W-1:0] p1_d, p2_d;
	logic signed [NP_W-1:0] pn_d;
	logic [TP_W:0]          r1, r2;
	logic [NP_W:0]          rn;
	logic signed [SUM_W-1:0] sum;
	logic signed [31:0]     sum32, sat;

	// Stall chain
	assign adv_o     = !out_v_q || accel.ready;
	assign adv3      = !v_s3 || adv_o;
	assign adv2      = !v_s2 || adv3;
	assign adv1      = !v_s1 || adv2;
	assign pop_ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (adv1)  v_s1    <= pop_valid;
			if (adv2)  v_s2    <= v_s1;
			if (adv3)  v_s3    <= v_s2;
			if (adv_o) out_v_q <= v_s3;
		end
	end

	// Stage 1: quarter-wave table read, two ports
	always_ff @(posedge clk) begin
		if (adv1 && pop_valid) begin
			rom1_s1  <= COS_ROM[pop_data[A1_LO +: ADDR_W]];
			rom2_s1  <= COS_ROM[pop_data[A2_LO +: ADDR_W]];
			neg1_s1  <= pop_data[N1_BIT];
			neg2_s1  <= pop_data[N2_BIT];
			en2_s1   <= pop_data[E2_BIT];
			noise_s1 <= $signed(pop_data[NOISE_W-1:0]);
		end
	end

	// Stage 2: signed cosine times amplitude, noise times amplitude
	assign cos1 = neg1_s1 ? -$signed({1'b0, rom1_s1}) : $signed({1'b0, rom1_s1});
	assign cos2 = neg2_s1 ? -$signed({1'b0, rom2_s1}) : $signed({1'b0, rom2_s1});
	assign p1_d = $signed({1'b0, amp1}) * cos1;
	assign p2_d = $signed({1'b0, amp2}) * cos2;
	assign pn_d = $signed({1'b0, namp}) * noise_s1;

	always_ff @(posedge clk) begin
		if (adv2 && v_s1) begin
			p1_s2  <= p1_d;
			p2_s2  <= p2_d;
			pn_s2  <= pn_d;
			en2_s2 <= en2_s1;
		end
	end

	// Stage 3: round half away from zero: (v + half - sign) >>> shift
	assign r1 = {p1_s2[TP_W-1], p1_s2} + (TP_W+1)'(TONE_HALF)
		- {{TP_W{1'b0}}, p1_s2[TP_W-1]};
	assign r2 = {p2_s2[TP_W-1], p2_s2} + (TP_W+1)'(TONE_HALF)
		- {{TP_W{1'b0}}, p2_s2[TP_W-1]};
	assign rn = {pn_s2[NP_W-1], pn_s2} + (NP_W+1)'(NOISE_HALF)
		- {{NP_W{1'b0}}, pn_s2[NP_W-1]};

	always_ff @(posedge clk) begin
		if (adv3 && v_s2) begin
			t1_s3 <= $signed(r1[TP_W -: TERM_W]);
			t2_s3 <= en2_s2 ? $signed(r2[TP_W -: TERM_W]) : '0;
			tn_s3 <= $signed(rn[NP_W -: TERM_W]);
		end
	end

	// Output: sum of the three terms, clamped to the sample range
	assign sum   = SUM_W'(t1_s3) + SUM_W'(t2_s3) + SUM_W'(tn_s3);
	assign sum32 = 32'(sum);
	always_comb begin
		if (sum32 > OUT_MAX) begin
			sat = OUT_MAX;
		end else if (sum32 < OUT_MIN) begin
			sat = OUT_MIN;
		end else begin
			sat = sum32;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_o && v_s3) begin
			sample_q <= $signed(sat[SAMPLE_W-1:0]);
		end
	end

	assign accel.valid  = out_v_q;
	assign accel.sample = sample_q;

	`ASSERT_CLK(a_pop_lands, pop_valid && pop_ready |=> v_s1, "popped word lost before stage 1")
	`ASSERT_CLK(a_s3_hold, v_s3 && !adv_o |=> v_s3 && $stable(t1_s3) && $stable(tn_s3), "stage 3 changed under a stall")
	`ASSERT_CLK(a_range, accel.valid |-> (accel.sample <= SAMPLE_BOUND) && (accel.sample >= -SAMPLE_BOUND), "sample beyond amplitude bound")

endmodule
